// ----- design/script_source_tokenizer_macros.svh -----
// assertion helpers shared by the tokenizer modules
`ifndef SCRIPT_SOURCE_TOKENIZER_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// next-cycle implication
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/sst_pkg.sv -----
package sst_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned KW_COUNT     = 5;

  localparam logic [31:0] SAT16_MAX = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_NUMDOT,
    MODE_STR
  } mode_e;

  typedef enum logic [4:0] {
    KIND_EOF     = 5'd0,
    KIND_IDENT   = 5'd1,
    KIND_INT     = 5'd2,
    KIND_FLOAT   = 5'd3,
    KIND_STRING  = 5'd4,
    KIND_GROWL   = 5'd5,
    KIND_LET     = 5'd6,
    KIND_PLUS    = 5'd7,
    KIND_MINUS   = 5'd8,
    KIND_STAR    = 5'd9,
    KIND_SLASH   = 5'd10,
    KIND_PERCENT = 5'd11,
    KIND_LPAREN  = 5'd12,
    KIND_RPAREN  = 5'd13,
    KIND_ASSIGN  = 5'd14,
    KIND_COLON   = 5'd15,
    KIND_UNKNOWN = 5'd16,
    KIND_UNTERM  = 5'd17
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
  } tok_t;

  // tokens caused by one source byte, t0 goes out first
  typedef struct packed {
    tok_t t0;
    tok_t t1;
    logic two;
  } rec_t;

  // keyword text, first char in the top byte, zero padded to eight chars
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"growl", 24'h0},
    {"let",   40'h0},
    {"str",   40'h0},
    {"int",   40'h0},
    {"float", 24'h0}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd3, 3'd3, 3'd3, 3'd5};

  localparam kind_e KW_KIND [KW_COUNT] = '{
    KIND_GROWL, KIND_LET, KIND_STRING, KIND_INT, KIND_FLOAT
  };

endpackage

// ----- design/script_source_tokenizer.sv -----
// Streaming tokenizer: takes one source byte per cycle unless stalled (byte 0
// ends the source) and returns tokens as kind, start offset, length, line and
// column, with last set on the final token caused by a byte. The scanner front
// end updates its mode and position counters on each accepted byte and hands
// the tokens a byte causes (zero, one or two) to a four-record queue. The back
// end shows one token per cycle from its output register while not stalled, so
// a byte that both ends an identifier or number and starts an operator, unknown
// or eof token yields two tokens in turn, the second held in a pending register;
// the queue soaks up such bursts and downstream stalls, and input stall is
// raised only when it is full.
module script_source_tokenizer #(
  parameter int unsigned POS_BITS = sst_pkg::POS_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  ch_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [4:0]  kind_o,
  output logic [15:0] start_res_o,
  output logic [15:0] length_o,
  output logic [15:0] line_no_o,
  output logic [15:0] col_no_o,
  output logic        last_o
);

  sst_pkg::rec_t front_rec, q_rec;
  sst_pkg::tok_t tok;
  logic          push, pop, full, empty;

  sst_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ch_i    (ch_i),
    .full_i  (full),
    .stall_o (stall_o),
    .push_o  (push),
    .rec_o   (front_rec)
  );

  sst_fifo #(
    .WIDTH($bits(sst_pkg::rec_t)),
    .DEPTH(sst_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_rec),
    .pop_i   (pop),
    .data_o  (q_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  sst_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (q_rec),
    .empty_i (empty),
    .pop_o   (pop),
    .stall_i (stall_i),
    .valid_o (valid_o),
    .tok_o   (tok),
    .last_o  (last_o)
  );

  assign kind_o      = tok.kind;
  assign start_res_o = tok.start;
  assign length_o    = tok.len;
  assign line_no_o   = tok.line;
  assign col_no_o    = tok.col;

endmodule

// ----- design/sst_front.sv -----
module sst_front #(
  parameter int unsigned POS_BITS = sst_pkg::POS_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    ch_i,
  input  logic          full_i,
  output logic          stall_o,
  output logic          push_o,
  output sst_pkg::rec_t rec_o
);

  localparam int unsigned P  = POS_BITS;
  localparam int unsigned FW = sst_pkg::FIELD_W;

  sst_pkg::mode_e mode_q, mode_d;
  logic           quote_q, quote_d;
  logic [4:0]     mask_q, mask_d;
  logic [P-1:0]   pos_q, pos_d;
  logic [P-1:0]   start_q, start_d;
  logic [P-1:0]   line_q, line_d;
  logic [P-1:0]   col_q, col_d;
  logic [P-1:0]   tline_q, tline_d;
  logic [P-1:0]   tcol_q, tcol_d;

  logic         accept;
  logic [7:0]   c;
  logic         is_dig, is_alp, is_idc, is_spc, is_nul, is_quote;
  logic         ident_cont, num_cont, ends_tok, do_idle, str_close, str_eof;
  logic [P-1:0] idx;
  logic [P-1:0] pos_step, line_step, col_step;
  logic         a_v, b_v;
  sst_pkg::tok_t tok_a, tok_b;

  function automatic logic [FW-1:0] sat16(input logic [P-1:0] v);
    return (v > P'(sst_pkg::SAT16_MAX)) ? '1 : FW'(v);
  endfunction

  // drop keywords that no longer match at this offset
  function automatic logic [4:0] kw_filter(input logic [4:0] m, input logic [P-1:0] i,
                                           input logic [7:0] b);
    logic [4:0] r;
    r = m;
    for (int k = 0; k < sst_pkg::KW_COUNT; k++) begin
      if (i >= P'(sst_pkg::KW_LEN[k]) ||
          sst_pkg::KW_TEXT[k][63 - 8 * i[2:0] -: 8] != b) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic sst_pkg::kind_e ident_kind(input logic [4:0] m, input logic [P-1:0] len);
    sst_pkg::kind_e kd;
    logic           found;
    kd    = sst_pkg::KIND_IDENT;
    found = 1'b0;
    for (int k = 0; k < sst_pkg::KW_COUNT; k++) begin
      if (!found && m[k] && len == P'(sst_pkg::KW_LEN[k])) begin
        kd    = sst_pkg::KW_KIND[k];
        found = 1'b1;
      end
    end
    return kd;
  endfunction

  function automatic sst_pkg::kind_e op_kind(input logic [7:0] b);
    sst_pkg::kind_e kd;
    case (b)
      "+":     kd = sst_pkg::KIND_PLUS;
      "-":     kd = sst_pkg::KIND_MINUS;
      "*":     kd = sst_pkg::KIND_STAR;
      "/":     kd = sst_pkg::KIND_SLASH;
      "%":     kd = sst_pkg::KIND_PERCENT;
      "(":     kd = sst_pkg::KIND_LPAREN;
      ")":     kd = sst_pkg::KIND_RPAREN;
      "=":     kd = sst_pkg::KIND_ASSIGN;
      ":":     kd = sst_pkg::KIND_COLON;
      default: kd = sst_pkg::KIND_UNKNOWN;
    endcase
    return kd;
  endfunction

  assign stall_o = full_i;
  assign accept  = valid_i && !full_i;
  assign c       = ch_i;

  assign is_dig   = c inside {["0":"9"]};
  assign is_alp   = c inside {["a":"z"], ["A":"Z"]};
  assign is_idc   = is_alp || is_dig || (c == "_");
  assign is_spc   = c inside {8'h20, [8'h09:8'h0D]};
  assign is_nul   = (c == 8'h00);
  assign is_quote = (c == "'") || (c == "\"");

  assign idx = pos_q - start_q;

  // position after this byte, saturating
  assign pos_step  = (&pos_q) ? pos_q : pos_q + P'(1);
  assign line_step = (c == 8'h0A && !(&line_q)) ? line_q + P'(1) : line_q;
  assign col_step  = (c == 8'h0A) ? P'(1) : ((&col_q) ? col_q : col_q + P'(1));

  assign ident_cont = (mode_q == sst_pkg::MODE_IDENT) && is_idc;
  assign num_cont   = ((mode_q == sst_pkg::MODE_NUM) || (mode_q == sst_pkg::MODE_NUMDOT)) &&
                      (is_dig || (c == "." && mode_q == sst_pkg::MODE_NUM));
  assign ends_tok   = ((mode_q == sst_pkg::MODE_IDENT) && !ident_cont) ||
                      (((mode_q == sst_pkg::MODE_NUM) || (mode_q == sst_pkg::MODE_NUMDOT)) &&
                       !num_cont);
  assign do_idle    = (mode_q == sst_pkg::MODE_IDLE) || ends_tok;
  assign str_close  = (mode_q == sst_pkg::MODE_STR) && (c == (quote_q ? "'" : "\""));
  assign str_eof    = (mode_q == sst_pkg::MODE_STR) && is_nul && !str_close;

  // next state
  always_comb begin
    logic step, clr;
    mode_d  = mode_q;
    quote_d = quote_q;
    mask_d  = mask_q;
    pos_d   = pos_q;
    start_d = start_q;
    line_d  = line_q;
    col_d   = col_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    step    = 1'b0;
    clr     = 1'b0;

    case (mode_q)
      sst_pkg::MODE_IDENT: begin
        if (ident_cont) begin
          mask_d = kw_filter(mask_q, idx, c);
          step   = 1'b1;
        end else begin
          mode_d = sst_pkg::MODE_IDLE;
          mask_d = '1;
        end
      end
      sst_pkg::MODE_NUM, sst_pkg::MODE_NUMDOT: begin
        if (num_cont) begin
          if (c == ".") mode_d = sst_pkg::MODE_NUMDOT;
          step = 1'b1;
        end else begin
          mode_d = sst_pkg::MODE_IDLE;
        end
      end
      sst_pkg::MODE_STR: begin
        if (str_close) begin
          step   = 1'b1;
          mode_d = sst_pkg::MODE_IDLE;
        end else if (is_nul) begin
          clr = 1'b1;
        end else begin
          step = 1'b1;
        end
      end
      default: mode_d = sst_pkg::MODE_IDLE;
    endcase

    if (do_idle) begin
      if (is_nul) begin
        clr = 1'b1;
      end else if (is_spc) begin
        step = 1'b1;
      end else if (is_alp || c == "_") begin
        start_d = pos_q;
        tline_d = line_q;
        tcol_d  = col_q;
        mode_d  = sst_pkg::MODE_IDENT;
        mask_d  = kw_filter('1, '0, c);
        step    = 1'b1;
      end else if (is_quote) begin
        // string text starts after the quote
        tline_d = line_q;
        tcol_d  = col_q;
        quote_d = (c == "'");
        mode_d  = sst_pkg::MODE_STR;
        start_d = pos_step;
        step    = 1'b1;
      end else if (is_dig) begin
        start_d = pos_q;
        tline_d = line_q;
        tcol_d  = col_q;
        mode_d  = sst_pkg::MODE_NUM;
        step    = 1'b1;
      end else begin
        step = 1'b1;
      end
    end

    if (step) begin
      pos_d  = pos_step;
      line_d = line_step;
      col_d  = col_step;
    end

    // end of source or unterminated string starts a new source
    if (clr) begin
      mode_d  = sst_pkg::MODE_IDLE;
      quote_d = 1'b0;
      mask_d  = '1;
      pos_d   = '0;
      start_d = '0;
      line_d  = P'(1);
      col_d   = P'(1);
      tline_d = P'(1);
      tcol_d  = P'(1);
    end
  end

  // tokens
  always_comb begin
    a_v        = ends_tok || str_close || str_eof;
    tok_a.start = sat16(start_q);
    tok_a.len   = sat16(idx);
    tok_a.line  = sat16(tline_q);
    tok_a.col   = sat16(tcol_q);
    if (str_eof) begin
      tok_a.kind = sst_pkg::KIND_UNTERM;
    end else if (str_close) begin
      tok_a.kind = sst_pkg::KIND_STRING;
    end else if (mode_q == sst_pkg::MODE_IDENT) begin
      tok_a.kind = ident_kind(mask_q, idx);
    end else if (mode_q == sst_pkg::MODE_NUMDOT) begin
      tok_a.kind = sst_pkg::KIND_FLOAT;
    end else begin
      tok_a.kind = sst_pkg::KIND_INT;
    end

    b_v = do_idle && !is_spc && !is_alp && (c != "_") && !is_quote && !is_dig;
    tok_b.kind  = is_nul ? sst_pkg::KIND_EOF : op_kind(c);
    tok_b.start = sat16(pos_q);
    tok_b.len   = is_nul ? '0 : FW'(1);
    tok_b.line  = sat16(line_q);
    tok_b.col   = sat16(col_q);

    rec_o.t0  = a_v ? tok_a : tok_b;
    rec_o.t1  = tok_b;
    rec_o.two = a_v && b_v;
    push_o    = accept && (a_v || b_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sst_pkg::MODE_IDLE;
      quote_q <= 1'b0;
      mask_q  <= '1;
      pos_q   <= '0;
      start_q <= '0;
      line_q  <= P'(1);
      col_q   <= P'(1);
      tline_q <= P'(1);
      tcol_q  <= P'(1);
    end else if (accept) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      mask_q  <= mask_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
    end
  end

endmodule

// ----- design/sst_fifo.sv -----
`include "script_source_tokenizer_macros.svh"

module sst_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sst_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `SST_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `SST_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

// ----- design/sst_back.sv -----
`include "script_source_tokenizer_macros.svh"

module sst_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sst_pkg::rec_t rec_i,
  input  logic          empty_i,
  output logic          pop_o,
  input  logic          stall_i,
  output logic          valid_o,
  output sst_pkg::tok_t tok_o,
  output logic          last_o
);

  logic          out_valid_q, out_valid_d;
  sst_pkg::tok_t out_tok_q, out_tok_d;
  logic          out_last_q, out_last_d;
  logic          pend_q, pend_d;
  sst_pkg::tok_t pend_tok_q, pend_tok_d;
  logic          load;

  // output register is free or being taken this cycle
  assign load  = !out_valid_q || !stall_i;
  assign pop_o = load && !pend_q && !empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_tok_d   = out_tok_q;
    out_last_d  = out_last_q;
    pend_d      = pend_q;
    pend_tok_d  = pend_tok_q;
    if (load) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_tok_d   = pend_tok_q;
        out_last_d  = 1'b1;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        out_tok_d   = rec_i.t0;
        out_last_d  = !rec_i.two;
        pend_d      = rec_i.two;
        pend_tok_d  = rec_i.t1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q  <= out_tok_d;
    out_last_q <= out_last_d;
    pend_tok_q <= pend_tok_d;
  end

  assign valid_o = out_valid_q;
  assign tok_o   = out_tok_q;
  assign last_o  = out_last_q;

  `SST_ASSERT_IMP(a_pend_behind_out, clk_i, rst_ni, pend_q, out_valid_q)
  `SST_ASSERT_IMP(a_pend_not_last, clk_i, rst_ni, pend_q, !out_last_q)
  `SST_ASSERT_NXT(a_pend_goes_last, clk_i, rst_ni, pend_q && !stall_i, out_valid_q && out_last_q)

endmodule

// ----- dv/token_checker.sv -----
module token_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        in_ch_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [4:0]        kind_i,
  input  logic [15:0]       start_i,
  input  logic [15:0]       length_i,
  input  logic [15:0]       line_i,
  input  logic [15:0]       col_i,
  input  logic              last_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       tokens_checked_o,
  output logic [17:0]       kinds_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sst_pkg::kind_e kind;
    logic [15:0]    start;
    logic [15:0]    len;
    logic [15:0]    line;
    logic [15:0]    col;
    logic           last;
  } token_t;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  string          kw_words [5] = '{"growl", "let", "str", "int", "float"};
  sst_pkg::kind_e kw_kinds [5] = '{sst_pkg::KIND_GROWL, sst_pkg::KIND_LET,
                                   sst_pkg::KIND_STRING, sst_pkg::KIND_INT,
                                   sst_pkg::KIND_FLOAT};

  // scanner state
  sst_pkg::mode_e scan_mode;
  logic           quote_single;
  logic [4:0]     kw_alive;
  logic [15:0]    src_pos;
  logic [15:0]    tok_start;
  logic [15:0]    cur_line;
  logic [15:0]    cur_col;
  logic [15:0]    tok_line;
  logic [15:0]    tok_col;

  token_t      expected_tokens [$];
  token_t      made [2];
  int          made_n;
  token_t      want;
  int unsigned mismatches = 0;
  int unsigned tokens_checked = 0;
  logic [17:0] kinds_seen = '0;

  assign fail_count_o     = mismatches;
  assign tokens_checked_o = tokens_checked;
  assign kinds_seen_o     = kinds_seen;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_ident(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic sst_pkg::kind_e op_kind(logic [7:0] c);
    case (c)
      "+":     return sst_pkg::KIND_PLUS;
      "-":     return sst_pkg::KIND_MINUS;
      "*":     return sst_pkg::KIND_STAR;
      "/":     return sst_pkg::KIND_SLASH;
      "%":     return sst_pkg::KIND_PERCENT;
      "(":     return sst_pkg::KIND_LPAREN;
      ")":     return sst_pkg::KIND_RPAREN;
      "=":     return sst_pkg::KIND_ASSIGN;
      ":":     return sst_pkg::KIND_COLON;
      default: return sst_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  function automatic void clear_scan();
    scan_mode    = sst_pkg::MODE_IDLE;
    quote_single = 1'b0;
    kw_alive     = '1;
    src_pos      = '0;
    tok_start    = '0;
    cur_line     = 16'd1;
    cur_col      = 16'd1;
    tok_line     = 16'd1;
    tok_col      = 16'd1;
  endfunction

  function automatic void step_pos(logic [7:0] c);
    if (c == 8'h0A) begin
      if (cur_line != COUNT_MAX) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col != COUNT_MAX) begin
      cur_col++;
    end
    if (src_pos != COUNT_MAX) src_pos++;
  endfunction

  function automatic void mark_start();
    tok_start = src_pos;
    tok_line  = cur_line;
    tok_col   = cur_col;
  endfunction

  // drop keywords whose text disagrees at the current offset
  function automatic void kw_update(logic [7:0] c);
    logic [15:0] idx;
    idx = src_pos - tok_start;
    for (int k = 0; k < 5; k++) begin
      if (kw_alive[k] && (idx >= kw_words[k].len() || kw_words[k][idx] != c))
        kw_alive[k] = 1'b0;
    end
  endfunction

  function automatic sst_pkg::kind_e ident_kind();
    logic [15:0] n;
    n = src_pos - tok_start;
    for (int k = 0; k < 5; k++) begin
      if (kw_alive[k] && n == kw_words[k].len()) return kw_kinds[k];
    end
    return sst_pkg::KIND_IDENT;
  endfunction

  function automatic void add_token(sst_pkg::kind_e k, logic [15:0] st, logic [15:0] n,
                                    logic [15:0] ln, logic [15:0] cl);
    token_t t;
    t.kind  = k;
    t.start = st;
    t.len   = n;
    t.line  = ln;
    t.col   = cl;
    t.last  = 1'b0;
    made[made_n] = t;
    made_n++;
  endfunction

  // tokens caused by one accepted source byte
  function automatic void scan_byte(logic [7:0] c);
    token_t     t;
    logic [7:0] q;
    bit         taken;
    taken  = 1'b0;
    made_n = 0;
    q      = quote_single ? "'" : "\"";
    case (scan_mode)
      sst_pkg::MODE_STR: begin
        taken = 1'b1;
        if (c == q) begin
          add_token(sst_pkg::KIND_STRING, tok_start, src_pos - tok_start, tok_line, tok_col);
          step_pos(c);
          scan_mode = sst_pkg::MODE_IDLE;
        end else if (c == 8'd0) begin
          add_token(sst_pkg::KIND_UNTERM, tok_start, src_pos - tok_start, tok_line, tok_col);
          clear_scan();
        end else begin
          step_pos(c);
        end
      end
      sst_pkg::MODE_IDENT: begin
        if (is_ident(c)) begin
          kw_update(c);
          step_pos(c);
          taken = 1'b1;
        end else begin
          add_token(ident_kind(), tok_start, src_pos - tok_start, tok_line, tok_col);
          scan_mode = sst_pkg::MODE_IDLE;
          kw_alive  = '1;
        end
      end
      sst_pkg::MODE_NUM, sst_pkg::MODE_NUMDOT: begin
        if (is_digit(c) || (c == "." && scan_mode == sst_pkg::MODE_NUM)) begin
          if (c == ".") scan_mode = sst_pkg::MODE_NUMDOT;
          step_pos(c);
          taken = 1'b1;
        end else begin
          add_token(scan_mode == sst_pkg::MODE_NUMDOT ? sst_pkg::KIND_FLOAT
                                                      : sst_pkg::KIND_INT,
                    tok_start, src_pos - tok_start, tok_line, tok_col);
          scan_mode = sst_pkg::MODE_IDLE;
        end
      end
      default: scan_mode = sst_pkg::MODE_IDLE;
    endcase

    // a byte that closed an identifier or number is rescanned from idle
    if (!taken) begin
      if (c == 8'd0) begin
        add_token(sst_pkg::KIND_EOF, src_pos, 16'd0, cur_line, cur_col);
        clear_scan();
      end else if (is_blank(c)) begin
        step_pos(c);
      end else if (is_alpha(c) || c == "_") begin
        mark_start();
        scan_mode = sst_pkg::MODE_IDENT;
        kw_alive  = '1;
        kw_update(c);
        step_pos(c);
      end else if (c == "\"" || c == "'") begin
        tok_line     = cur_line;
        tok_col      = cur_col;
        quote_single = (c == "'");
        scan_mode    = sst_pkg::MODE_STR;
        step_pos(c);
        tok_start    = src_pos;
      end else if (is_digit(c)) begin
        mark_start();
        scan_mode = sst_pkg::MODE_NUM;
        step_pos(c);
      end else begin
        add_token(op_kind(c), src_pos, 16'd1, cur_line, cur_col);
        step_pos(c);
      end
    end

    for (int i = 0; i < made_n; i++) begin
      t      = made[i];
      t.last = (i == made_n - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_tokens.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) scan_byte(in_ch_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                   $time, kind_i, start_i);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("start", want.start, start_i);
          check_field("length", want.len, length_i);
          check_field("line", want.line, line_i);
          check_field("column", want.col, col_i);
          check_field("last", want.last, last_i);
          kinds_seen[want.kind] = 1'b1;
          tokens_checked++;
        end
      end
      pending_o <= expected_tokens.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int unsigned {
    SHAPE_IDENT,
    SHAPE_WORD,
    SHAPE_NUMBER,
    SHAPE_STRING,
    SHAPE_OP,
    SHAPE_ODD
  } shape_e;

  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        valid_i = 1'b0;
  logic [7:0]  ch_i    = 8'd0;
  logic        stall_i = 1'b0;
  logic        stall_o;
  logic        valid_o;
  logic [4:0]  kind_o;
  logic [15:0] start_res_o;
  logic [15:0] length_o;
  logic [15:0] line_no_o;
  logic [15:0] col_no_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned tokens_checked;
  logic [17:0] kinds_seen;

  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned stretch_left  = 0;
  int unsigned stall_pct     = 0;
  int unsigned stall_levels [4] = '{0, 20, 50, 85};
  int unsigned burst_left    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cycle_count   = 0;
  bit          steady        = 1'b0;

  string       head_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string       tail_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string       digit_chars  = "0123456789";
  string       op_chars     = "+-*/%()=:";
  string       keyword_list [5] = '{"growl", "let", "str", "int", "float"};
  logic [7:0]  blank_chars [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
  logic [7:0]  src [$];

  always #10 clk_i = ~clk_i;

  script_source_tokenizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .ch_i        (ch_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .kind_o      (kind_o),
    .start_res_o (start_res_o),
    .length_o    (length_o),
    .line_no_o   (line_no_o),
    .col_no_o    (col_no_o),
    .last_o      (last_o)
  );

  token_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (valid_i),
    .in_stall_i       (stall_o),
    .in_ch_i          (ch_i),
    .out_valid_i      (valid_o),
    .out_stall_i      (stall_i),
    .kind_i           (kind_o),
    .start_i          (start_res_o),
    .length_i         (length_o),
    .line_i           (line_no_o),
    .col_i            (col_no_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .tokens_checked_o (tokens_checked),
    .kinds_seen_o     (kinds_seen)
  );

  // receiver: random stall density per stretch, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      stall_i <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 200);
        stall_pct    = stall_levels[$urandom_range(0, 3)];
      end else begin
        stretch_left--;
      end
      stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // sender works in bursts with random gaps unless held steady
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left != 0) burst_left--;
    valid_i <= 1'b1;
    ch_i    <= b;
    do @(posedge clk_i); while (stall_o);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // one random source: mostly well-formed tokens, some noise
  function automatic void build_source();
    int unsigned n;
    shape_e      shape;
    logic [7:0]  quote;
    logic [7:0]  b;
    string       w;
    src.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) src.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 12)) begin
      shape = shape_e'($urandom_range(0, SHAPE_ODD));
      case (shape)
        SHAPE_IDENT: begin
          src.push_back(head_chars[$urandom_range(0, head_chars.len() - 1)]);
          repeat ($urandom_range(0, 7))
            src.push_back(tail_chars[$urandom_range(0, tail_chars.len() - 1)]);
        end
        SHAPE_WORD: begin
          w = keyword_list[$urandom_range(0, 4)];
          // truncated or extended keywords must stay identifiers
          if ($urandom_range(0, 3) == 0) w = w.substr(0, $urandom_range(0, w.len() - 2));
          for (int i = 0; i < w.len(); i++) src.push_back(w[i]);
          if ($urandom_range(0, 3) == 0)
            src.push_back(tail_chars[$urandom_range(0, tail_chars.len() - 1)]);
        end
        SHAPE_NUMBER: begin
          repeat ($urandom_range(1, 5)) src.push_back(digit_chars[$urandom_range(0, 9)]);
          if ($urandom_range(0, 1) == 1) begin
            src.push_back(".");
            repeat ($urandom_range(0, 3)) src.push_back(digit_chars[$urandom_range(0, 9)]);
            if ($urandom_range(0, 5) == 0) src.push_back(".");
          end
        end
        SHAPE_STRING: begin
          quote = ($urandom_range(0, 1) == 1) ? "'" : "\"";
          src.push_back(quote);
          repeat ($urandom_range(0, 6)) begin
            do b = 8'($urandom_range(1, 255)); while (b == quote);
            src.push_back(b);
          end
          src.push_back(quote);
        end
        SHAPE_OP: src.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        default:  src.push_back(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) src.push_back(blank_chars[$urandom_range(0, 5)]);
    end
    // source cut off inside a string
    if ($urandom_range(0, 9) == 0) begin
      src.push_back("'");
      src.push_back(head_chars[$urandom_range(0, head_chars.len() - 1)]);
    end
    src.push_back(8'd0);
  endfunction

  initial begin
    int unsigned counted;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keyword, blank, both quotes, newline, second dot, all operators, high bytes,
    // identifier pending at end of source, unterminated string
    send_text("growl\t'q\"'\n7.5.+-*/%()=:\200a");
    send_byte(8'd0);
    send_text("'\377");
    send_byte(8'd0);
    wait_drained();

    // long receiver hold-off while operators keep coming
    hold_requests <= hold_requests + 1;
    steady = 1'b1;
    repeat (40) send_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
    send_byte(8'd0);
    steady = 1'b0;
    wait_drained();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      build_source();
      if ($urandom_range(0, 29) == 0) hold_requests <= hold_requests + 1;
      foreach (src[i]) begin
        send_byte(src[i]);
        counted++;
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d source bytes, checked %0d tokens covering %0d of 18 token kinds",
             bytes_sent, tokens_checked, $countones(kinds_seen));
    $display("bursty input with random gaps, output held off long enough to stall input");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/sst_pkg.sv
design/sst_front.sv
design/sst_fifo.sv
design/sst_back.sv
design/script_source_tokenizer.sv
dv/token_checker.sv
dv/tb_top.sv
